// File: design/ggc_pkg.sv
// ----------------------------------------------------------------------------
// ggc_pkg: shared definitions for the greedy graph colouring block
// Field widths, default sizes, request codes and the colour scan width.
// ----------------------------------------------------------------------------
package ggc_pkg;

   localparam int unsigned VertexWidth = 10;
   localparam int unsigned ColorWidth  = 6;
   localparam int unsigned CountWidth  = 7;

   localparam int unsigned MaxVerticesDefault = 1024;
   localparam int unsigned MaxColorsDefault   = 64;

   // The free-colour search looks at ScanChunk (1 << ChunkBits) colours per cycle.
   localparam int unsigned ChunkBits = 3;
   localparam int unsigned ScanChunk = 1 << ChunkBits;

   typedef enum logic {
      REQ_NEIGHBOR = 1'b0,
      REQ_CLEAR    = 1'b1
   } req_kind_type;

endpackage

// File: design/ggc_req_if.sv
// ----------------------------------------------------------------------------
// ggc_req_if: request channel
// Valid/ready channel carrying one neighbour entry or a clear request.
// ----------------------------------------------------------------------------
interface ggc_req_if import ggc_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [VertexWidth-1:0] vertex;
   logic [VertexWidth-1:0] neighbor;
   logic                   has_neighbor;
   logic                   last;

   modport source (
      output valid, req_type, vertex, neighbor, has_neighbor, last,
      input  ready
   );

   modport sink (
      input  valid, req_type, vertex, neighbor, has_neighbor, last,
      output ready
   );

endinterface

// File: design/ggc_rsp_if.sv
// ----------------------------------------------------------------------------
// ggc_rsp_if: response channel
// Valid/ready channel carrying the colour given to one vertex.
// ----------------------------------------------------------------------------
interface ggc_rsp_if import ggc_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [VertexWidth-1:0] vertex_out;
   logic [ColorWidth-1:0]  color;
   logic [CountWidth-1:0]  colors_used;
   logic                   overflow;

   modport source (
      output valid, vertex_out, color, colors_used, overflow,
      input  ready
   );

   modport sink (
      input  valid, vertex_out, color, colors_used, overflow,
      output ready
   );

endinterface

// File: design/ggc_ram.sv
// ----------------------------------------------------------------------------
// ggc_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ggc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/greedy_graph_coloring.sv
// ----------------------------------------------------------------------------
// greedy_graph_coloring: first-fit greedy vertex colouring
// Looks up neighbour colours, picks the smallest free colour for each vertex.
// ----------------------------------------------------------------------------
// After reset, and after every clear request, the block sweeps all
// MAX_VERTICES entries of the vertex memory to mark every vertex
// uncoloured; no request is taken during that sweep. A neighbour entry
// that names an in-range neighbour also reads the vertex memory and
// visits S_LOOK, since the stored colour comes back from the registered
// read port. The entry flagged last adds the free-colour search, which
// examines eight colours a cycle, and a write-back that stores the
// vertex colour and loads the response register. A waiting response does
// not stop the next request from being taken; only the next write-back
// waits for it to be transferred.
// ----------------------------------------------------------------------------
module greedy_graph_coloring import ggc_pkg::*; #(
   parameter int unsigned MAX_VERTICES = MaxVerticesDefault,
   parameter int unsigned MAX_COLORS   = MaxColorsDefault
) (
   input  logic       clock,
   input  logic       reset,
   ggc_req_if.sink    req_chan,
   ggc_rsp_if.source  rsp_chan
);

   localparam int unsigned AddrW     = $clog2(MAX_VERTICES);
   localparam int unsigned ColW      = $clog2(MAX_COLORS);
   localparam int unsigned CntW      = $clog2(MAX_COLORS + 1);
   localparam int unsigned NumChunks = (MAX_COLORS + ScanChunk - 1) / ScanChunk;
   localparam int unsigned ChW       = (NumChunks > 1) ? $clog2(NumChunks) : 1;
   localparam int unsigned PadW      = NumChunks * ScanChunk;
   localparam int unsigned WordW     = ColW + 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOOK   = 5'b00010,
      S_SEARCH = 5'b00100,
      S_WRITE  = 5'b01000,
      S_CLEAR  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [AddrW-1:0]       sweep_ff, sweep_in;
   logic [MAX_COLORS-1:0]  used_ff, used_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic [ChW-1:0]         chunk_ff, chunk_in;
   logic [ColW-1:0]        color_ff, color_in;
   logic                   found_ff, found_in;
   logic [VertexWidth-1:0] vertex_ff, vertex_in;
   logic                   last_ff, last_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VertexWidth-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic [ColorWidth-1:0]  rsp_color_ff, rsp_color_in;
   logic [CountWidth-1:0]  rsp_count_ff, rsp_count_in;
   logic                   rsp_over_ff, rsp_over_in;

   logic                   mem_wr_en;
   logic [AddrW-1:0]       mem_wr_addr;
   logic [WordW-1:0]       mem_wr_data;
   logic                   mem_rd_en;
   logic [WordW-1:0]       mem_rd_data;
   logic                   rd_mark;
   logic [ColW-1:0]        rd_color;

   logic [PadW-1:0]        used_pad;
   logic [ScanChunk-1:0]   chunk_bits;
   logic                   zero_hit;
   logic [ChunkBits-1:0]   zero_pos;

   logic                   req_accept;
   logic                   nb_in_range;
   logic                   v_in_range;
   logic                   rsp_free;
   logic [CntW-1:0]        cand_count;

   ggc_ram #(
      .WIDTH (WordW),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (AddrW'(req_chan.neighbor)),
      .rd_data (mem_rd_data)
   );

   assign rd_mark  = mem_rd_data[WordW-1];
   assign rd_color = mem_rd_data[ColW-1:0];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign nb_in_range    = (32'(req_chan.neighbor) < MAX_VERTICES);
   assign v_in_range     = (32'(vertex_ff) < MAX_VERTICES);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign cand_count     = CntW'(color_ff) + CntW'(1);

   // Colours beyond MAX_COLORS read as taken, so the last chunk never
   // reports a colour that does not exist.
   always_comb begin
      used_pad                   = '1;
      used_pad[MAX_COLORS-1:0]   = used_ff;
      chunk_bits = used_pad[{chunk_ff, ChunkBits'(0)} +: ScanChunk];
      zero_hit   = 1'b0;
      zero_pos   = '0;
      for (int i = ScanChunk - 1; i >= 0; i--) begin
         if (!chunk_bits[i]) begin
            zero_hit = 1'b1;
            zero_pos = ChunkBits'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      chunk_in      = chunk_ff;
      color_in      = color_ff;
      found_in      = found_ff;
      vertex_in     = vertex_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_over_in   = rsp_over_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = sweep_ff;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               vertex_in = req_chan.vertex;
               last_in   = req_chan.last;
               chunk_in  = '0;
               if (req_chan.req_type == REQ_CLEAR) begin
                  used_in  = '0;
                  count_in = '0;
                  sweep_in = '0;
                  state_in = S_CLEAR;
               end else if (req_chan.has_neighbor && nb_in_range) begin
                  mem_rd_en = 1'b1;
                  state_in  = S_LOOK;
               end else if (req_chan.last) begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_LOOK: begin
            if (rd_mark && (32'(rd_color) < MAX_COLORS)) begin
               used_in[rd_color] = 1'b1;
            end
            state_in = last_ff ? S_SEARCH : S_IDLE;
         end
         S_SEARCH: begin
            if (zero_hit) begin
               found_in = 1'b1;
               color_in = ColW'({chunk_ff, zero_pos});
               state_in = S_WRITE;
            end else if (chunk_ff == ChW'(NumChunks - 1)) begin
               found_in = 1'b0;
               state_in = S_WRITE;
            end else begin
               chunk_in = chunk_ff + ChW'(1);
            end
         end
         S_WRITE: begin
            if (rsp_free) begin
               // An overflowed vertex is written back as uncoloured.
               mem_wr_en   = v_in_range;
               mem_wr_addr = AddrW'(vertex_ff);
               mem_wr_data = found_ff ? {1'b1, color_ff} : '0;
               if (found_ff && (cand_count > count_ff)) begin
                  count_in = cand_count;
               end
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = vertex_ff;
               rsp_color_in  = found_ff ? ColorWidth'(color_ff) : '0;
               rsp_count_in  = (found_ff && (cand_count > count_ff)) ?
                               CountWidth'(cand_count) : CountWidth'(count_ff);
               rsp_over_in   = !found_ff;
               used_in       = '0;
               state_in      = S_IDLE;
            end
         end
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = '0;
            sweep_in    = sweep_ff + AddrW'(1);
            if (sweep_ff == AddrW'(MAX_VERTICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         chunk_ff     <= '0;
         found_ff     <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         chunk_ff     <= chunk_in;
         found_ff     <= found_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff      <= color_in;
      vertex_ff     <= vertex_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_over_ff   <= rsp_over_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.vertex_out  = rsp_vertex_ff;
   assign rsp_chan.color       = rsp_color_ff;
   assign rsp_chan.colors_used = rsp_count_ff;
   assign rsp_chan.overflow    = rsp_over_ff;

`ifndef ASSERT_OFF
   // A colour that was found always lies below the count after write-back.
   a_count_covers_color: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && rsp_free && found_ff) |=> (count_ff > CntW'(color_ff))
   ) else $error("colour count does not cover the colour just given");

   // The search never runs past the last chunk of the colour set.
   a_chunk_in_range: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (32'(chunk_ff) < NumChunks)
   ) else $error("colour search ran past the last chunk");

   // The used set is empty whenever a new vertex may begin.
   a_used_cleared: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && rsp_free) |=> (used_ff == '0)
   ) else $error("used colour set not emptied after a vertex");

   // The colour count never exceeds the number of colours.
   a_count_bound: assert property (
      @(posedge clock) disable iff (reset)
      (32'(count_ff) <= MAX_COLORS)
   ) else $error("colour count beyond the number of colours");
`endif

endmodule
